/* rtl/euler_to_quaternion_defines.svh */
// Assertion macros shared by the euler_to_quaternion RTL.
// Included by the files that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH

// Checked on every clock edge outside of reset.
`define E2Q_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define E2Q_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/e2q_pkg.sv */
// Package for the Euler angle to quaternion pipeline: widths, constants, types
// and the elaboration-time arctangent table. No dependencies.
package e2q_pkg;

  localparam int ANGLE_BITS    = 32;
  localparam int CORDIC_STAGES = 24;

  // Input and output word widths.
  localparam int IN_W  = 32;
  localparam int Q_W   = 32;
  // Angle magnitude (up to 2^31), scale constant and its halves.
  localparam int MAG_W   = 32;
  localparam int CONST_W = 64;
  localparam int HALF_W  = CONST_W / 2;
  localparam int PROD_W  = MAG_W + CONST_W;
  localparam int PHASE_SHIFT = 93 - ANGLE_BITS;
  // CORDIC datapath widths.
  localparam int XY_W = 43;
  localparam int Z_W  = ANGLE_BITS + 2;
  localparam int MUL_W = 2 * Q_W;

  // Pipeline depths of the three sections.
  localparam int PHASE_LAT  = 4;
  localparam int CORDIC_LAT = CORDIC_STAGES + 1;
  localparam int COMB_LAT   = 4;
  localparam int PIPE_LAT   = PHASE_LAT + CORDIC_LAT + COMB_LAT;

  // 2^64/pi for radians in Q4.27, 2^71/360 for degrees in Q10.21.
  localparam logic [CONST_W-1:0] C_RAD = 64'h517CC1B727220A95;
  localparam logic [CONST_W-1:0] C_DEG = 64'd6558842337318951686;

  typedef logic signed [IN_W-1:0]  angle_t;
  typedef logic signed [Q_W-1:0]   q30_t;
  typedef logic signed [Z_W-1:0]   zphase_t;
  typedef logic signed [XY_W-1:0]  cxy_t;
  typedef logic signed [MUL_W-1:0] prod_t;

  typedef struct packed {
    q30_t c;
    q30_t s;
  } sincos_t;

  // Inverse CORDIC gain in Q40 and unity in Q2.30.
  localparam cxy_t K_Q40   = 43'sd667681663043;
  localparam q30_t ONE_Q30 = 32'sd1073741824;

  // Restoring division, used only while building constants.
  function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Arctangent of 2^-i as a phase of ANGLE_BITS bits per full turn.
  // The series for atan is summed in Q62, then scaled by 2^64/pi.
  function automatic zphase_t atan_entry(input int i);
    logic signed [63:0] acc;
    logic [63:0]        term;
    logic [127:0]       prod;
    int                 k;
    acc = '0;
    if (i == 0) begin
      return zphase_t'(64'd1 << (ANGLE_BITS - 3));
    end
    k = 0;
    while (62 - i * (2 * k + 1) >= 0) begin
      term = long_div(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
      if (k[0]) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
      k++;
    end
    prod = {64'd0, acc} * {64'd0, C_RAD};
    prod = prod + (128'd1 << (126 - ANGLE_BITS));
    return zphase_t'(prod >> (127 - ANGLE_BITS));
  endfunction

endpackage

/* rtl/e2q_in_if.sv */
// Input channel of the Euler angle to quaternion block: valid/ready and three angles.
// Depends on e2q_pkg.
interface e2q_in_if
  import e2q_pkg::*;
();

  logic   valid;
  logic   ready;
  angle_t yaw_angle;
  angle_t pitch_angle;
  angle_t roll_angle;

  modport source (output valid, output yaw_angle, output pitch_angle, output roll_angle,
                  input ready);
  modport sink (input valid, input yaw_angle, input pitch_angle, input roll_angle,
                output ready);
endinterface

/* rtl/e2q_out_if.sv */
// Result channel of the Euler angle to quaternion block: valid/ready and the quaternion.
// Depends on e2q_pkg.
interface e2q_out_if
  import e2q_pkg::*;
();

  logic valid;
  logic ready;
  q30_t quat_w;
  q30_t quat_x;
  q30_t quat_y;
  q30_t quat_z;

  modport source (output valid, output quat_w, output quat_x, output quat_y, output quat_z,
                  input ready);
  modport sink (input valid, input quat_w, input quat_x, input quat_y, input quat_z,
                output ready);
endinterface

/* rtl/euler_to_quaternion.sv */
// Converts yaw, pitch and roll to the unit quaternion of the yaw-pitch-roll rotation,
// one word per clock cycle, through 4 phase stages, a 24-stage CORDIC plus its output
// stage, and 4 product stages. The whole pipeline advances together and holds while a
// result waits for out_chan.ready. degree_mode selects radian (Q4.27) or degree
// (Q10.21) angles and may be written only while no word is in flight. Results are Q2.30.
// Depends on e2q_pkg, e2q_in_if, e2q_out_if, e2q_phase, e2q_cordic and e2q_combine.
`include "euler_to_quaternion_defines.svh"

module euler_to_quaternion
  import e2q_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  e2q_in_if.sink     in_chan,
  e2q_out_if.source  out_chan,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  logic       deg_r;
  logic       en;
  logic       valid_r [PIPE_LAT];
  logic [1:0] quad_yaw, quad_pitch, quad_roll;
  zphase_t    res_yaw, res_pitch, res_roll;
  sincos_t    sc_yaw, sc_pitch, sc_roll;
  logic       out_in_range;

  // The pipeline moves whenever the output register is free or being taken.
  assign en            = !valid_r[PIPE_LAT-1] || out_chan.ready;
  assign in_chan.ready = en;
  assign out_chan.valid = valid_r[PIPE_LAT-1];

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r <= 1'b0;
    end else if (cfg_wr_en) begin
      deg_r <= cfg_wr_data;
    end
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PIPE_LAT; k++) begin
        valid_r[k] <= 1'b0;
      end
    end else if (en) begin
      valid_r[0] <= in_chan.valid;
      for (int k = 1; k < PIPE_LAT; k++) begin
        valid_r[k] <= valid_r[k-1];
      end
    end
  end

  e2q_phase u_phase_yaw (
    .clk(clk), .en(en), .degree_mode(deg_r), .angle(in_chan.yaw_angle),
    .quad(quad_yaw), .resid(res_yaw)
  );
  e2q_phase u_phase_pitch (
    .clk(clk), .en(en), .degree_mode(deg_r), .angle(in_chan.pitch_angle),
    .quad(quad_pitch), .resid(res_pitch)
  );
  e2q_phase u_phase_roll (
    .clk(clk), .en(en), .degree_mode(deg_r), .angle(in_chan.roll_angle),
    .quad(quad_roll), .resid(res_roll)
  );

  e2q_cordic u_cordic_yaw (
    .clk(clk), .en(en), .quad(quad_yaw), .resid(res_yaw), .sc(sc_yaw)
  );
  e2q_cordic u_cordic_pitch (
    .clk(clk), .en(en), .quad(quad_pitch), .resid(res_pitch), .sc(sc_pitch)
  );
  e2q_cordic u_cordic_roll (
    .clk(clk), .en(en), .quad(quad_roll), .resid(res_roll), .sc(sc_roll)
  );

  e2q_combine u_combine (
    .clk(clk), .en(en), .yaw(sc_yaw), .pitch(sc_pitch), .roll(sc_roll),
    .quat_w(out_chan.quat_w), .quat_x(out_chan.quat_x),
    .quat_y(out_chan.quat_y), .quat_z(out_chan.quat_z)
  );

  // All four delivered components lie within plus or minus one.
  assign out_in_range = out_chan.quat_w <= ONE_Q30 && out_chan.quat_w >= -ONE_Q30 &&
                        out_chan.quat_x <= ONE_Q30 && out_chan.quat_x >= -ONE_Q30 &&
                        out_chan.quat_y <= ONE_Q30 && out_chan.quat_y >= -ONE_Q30 &&
                        out_chan.quat_z <= ONE_Q30 && out_chan.quat_z >= -ONE_Q30;

  // Every delivered component lies within plus or minus one.
  `E2Q_ASSERT(a_out_range, out_chan.valid |-> out_in_range, "quaternion component out of range")
  // A held result freezes the pipeline, so no new word may enter.
  `E2Q_ASSERT(a_stall_blocks_input, (out_chan.valid && !out_chan.ready) |-> !in_chan.ready, "input taken while pipeline is stalled")
  // Reset empties the pipeline.
  `E2Q_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_chan.valid, "result valid right after reset")

endmodule

/* rtl/e2q_phase.sv */
// Angle to half-angle phase conversion, four pipeline stages.
// Gives the quadrant and the signed residual phase for the CORDIC. Depends on e2q_pkg.
module e2q_phase
  import e2q_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  logic                   degree_mode,
  input  angle_t                 angle,
  output logic [1:0]             quad,
  output zphase_t                resid
);

  logic [MAG_W-1:0]      mag_r;
  logic                  neg_r;
  logic                  deg_r;
  logic [CONST_W-1:0]    cst;
  logic [CONST_W-1:0]    plo_r, plo_nxt;
  logic [CONST_W-1:0]    phi_r, phi_nxt;
  logic                  neg2_r;
  logic [PROD_W-1:0]     psum;
  logic [ANGLE_BITS-1:0] raw_r;
  logic                  neg3_r;
  logic [ANGLE_BITS-1:0] ph;
  logic [ANGLE_BITS-1:0] ph_off;
  logic [1:0]            quad_r, quad_nxt;
  zphase_t               resid_r, resid_nxt;

  // Partial products of |angle| with the two halves of the scale constant.
  always_comb begin
    cst     = deg_r ? C_DEG : C_RAD;
    plo_nxt = CONST_W'(mag_r) * CONST_W'(cst[HALF_W-1:0]);
    phi_nxt = CONST_W'(mag_r) * CONST_W'(cst[CONST_W-1:HALF_W]);
  end

  // Join the partial products and round off the fraction below the phase.
  assign psum = {phi_r, {HALF_W{1'b0}}} + PROD_W'(plo_r) + (PROD_W'(1) << (PHASE_SHIFT - 1));

  // Restore the sign, then split the phase into quadrant and residual.
  always_comb begin
    ph        = neg3_r ? (ANGLE_BITS'(0) - raw_r) : raw_r;
    ph_off    = ph + (ANGLE_BITS'(1) << (ANGLE_BITS - 3));
    quad_nxt  = ph_off[ANGLE_BITS-1 -: 2];
    resid_nxt = zphase_t'($signed(ph - {quad_nxt, {(ANGLE_BITS - 2){1'b0}}}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= angle[IN_W-1] ? (MAG_W'(0) - MAG_W'(angle)) : MAG_W'(angle);
      neg_r   <= angle[IN_W-1];
      deg_r   <= degree_mode;
      plo_r   <= plo_nxt;
      phi_r   <= phi_nxt;
      neg2_r  <= neg_r;
      raw_r   <= psum[PHASE_SHIFT +: ANGLE_BITS];
      neg3_r  <= neg2_r;
      quad_r  <= quad_nxt;
      resid_r <= resid_nxt;
    end
  end

  assign quad  = quad_r;
  assign resid = resid_r;

endmodule

/* rtl/e2q_cordic.sv */
// Rotation-mode CORDIC, one register stage per iteration, then rounding,
// saturation and quadrant rotation into cosine and sine. Depends on e2q_pkg.
module e2q_cordic
  import e2q_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  logic [1:0] quad,
  input  zphase_t    resid,
  output sincos_t    sc
);

  cxy_t       x_r [CORDIC_STAGES];
  cxy_t       y_r [CORDIC_STAGES];
  zphase_t    z_r [CORDIC_STAGES];
  logic [1:0] q_r [CORDIC_STAGES];
  q30_t       cr, sr;
  sincos_t    sc_r, sc_nxt;

  // Round off ten fraction bits and clamp to plus or minus one.
  function automatic q30_t round_sat(input cxy_t v);
    cxy_t t;
    t = (v + cxy_t'(512)) >>> 10;
    if (t > cxy_t'(ONE_Q30)) begin
      return ONE_Q30;
    end
    if (t < -cxy_t'(ONE_Q30)) begin
      return -ONE_Q30;
    end
    return q30_t'(t);
  endfunction

  // One micro-rotation per stage.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam zphase_t ATAN = atan_entry(i);
    cxy_t       x_in, y_in;
    zphase_t    z_in;
    logic [1:0] q_in;

    if (i == 0) begin : g_first
      assign x_in = K_Q40;
      assign y_in = '0;
      assign z_in = resid;
      assign q_in = quad;
    end else begin : g_next
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign z_in = z_r[i-1];
      assign q_in = q_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_in[Z_W-1]) begin
          x_r[i] <= x_in - (y_in >>> i);
          y_r[i] <= y_in + (x_in >>> i);
          z_r[i] <= z_in - ATAN;
        end else begin
          x_r[i] <= x_in + (y_in >>> i);
          y_r[i] <= y_in - (x_in >>> i);
          z_r[i] <= z_in + ATAN;
        end
        q_r[i] <= q_in;
      end
    end
  end

  // Scale to Q2.30 and rotate by the quadrant.
  always_comb begin
    cr = round_sat(x_r[CORDIC_STAGES-1]);
    sr = round_sat(y_r[CORDIC_STAGES-1]);
    case (q_r[CORDIC_STAGES-1])
      2'd0: begin
        sc_nxt.c = cr;
        sc_nxt.s = sr;
      end
      2'd1: begin
        sc_nxt.c = -sr;
        sc_nxt.s = cr;
      end
      2'd2: begin
        sc_nxt.c = -cr;
        sc_nxt.s = -sr;
      end
      default: begin
        sc_nxt.c = sr;
        sc_nxt.s = -cr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_r <= sc_nxt;
    end
  end

  assign sc = sc_r;

endmodule

/* rtl/e2q_combine.sv */
// Quaternion assembly from the three sine/cosine pairs: pair products, rounding,
// triple products, sums and saturation in four register stages. Depends on e2q_pkg.
module e2q_combine
  import e2q_pkg::*;
(
  input  logic    clk,
  input  logic    en,
  input  sincos_t yaw,
  input  sincos_t pitch,
  input  sincos_t roll,
  output q30_t    quat_w,
  output q30_t    quat_x,
  output q30_t    quat_y,
  output q30_t    quat_z
);

  prod_t   pt_r, pu_r, pv_r, pg_r;
  sincos_t roll1_r, roll2_r;
  q30_t    t_r, u_r, v_r, g_r;
  prod_t   tc_r, us_r, ts_r, uc_r, vc_r, gs_r, gc_r, vs_r;
  q30_t    w_r, x_r, y_r, z_r;

  // Round a Q4.60 product back to Q2.30.
  function automatic prod_t rnd30(input prod_t p);
    return (p + (prod_t'(1) << 29)) >>> 30;
  endfunction

  // Round and clamp a component to plus or minus one.
  function automatic q30_t sat30(input prod_t p);
    prod_t r;
    r = rnd30(p);
    if (r > prod_t'(ONE_Q30)) begin
      return ONE_Q30;
    end
    if (r < -prod_t'(ONE_Q30)) begin
      return -ONE_Q30;
    end
    return q30_t'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      // Yaw by pitch products.
      pt_r    <= prod_t'(yaw.c) * prod_t'(pitch.c);
      pu_r    <= prod_t'(yaw.s) * prod_t'(pitch.s);
      pv_r    <= prod_t'(yaw.c) * prod_t'(pitch.s);
      pg_r    <= prod_t'(yaw.s) * prod_t'(pitch.c);
      roll1_r <= roll;
      // Back to Q2.30.
      t_r     <= q30_t'(rnd30(pt_r));
      u_r     <= q30_t'(rnd30(pu_r));
      v_r     <= q30_t'(rnd30(pv_r));
      g_r     <= q30_t'(rnd30(pg_r));
      roll2_r <= roll1_r;
      // Products with the roll terms.
      tc_r    <= prod_t'(t_r) * prod_t'(roll2_r.c);
      us_r    <= prod_t'(u_r) * prod_t'(roll2_r.s);
      ts_r    <= prod_t'(t_r) * prod_t'(roll2_r.s);
      uc_r    <= prod_t'(u_r) * prod_t'(roll2_r.c);
      vc_r    <= prod_t'(v_r) * prod_t'(roll2_r.c);
      gs_r    <= prod_t'(g_r) * prod_t'(roll2_r.s);
      gc_r    <= prod_t'(g_r) * prod_t'(roll2_r.c);
      vs_r    <= prod_t'(v_r) * prod_t'(roll2_r.s);
      // Components.
      w_r     <= sat30(tc_r + us_r);
      x_r     <= sat30(ts_r - uc_r);
      y_r     <= sat30(vc_r + gs_r);
      z_r     <= sat30(gc_r - vs_r);
    end
  end

  assign quat_w = w_r;
  assign quat_x = x_r;
  assign quat_y = y_r;
  assign quat_z = z_r;

endmodule

/* test/tb_top.sv */
// Self-checking testbench for euler_to_quaternion: random and directed angle words,
// predicted quaternions compared field by field. Depends on e2q_pkg, e2q_in_if,
// e2q_out_if and the euler_to_quaternion RTL.
`timescale 1ns / 100ps

module tb_top
  import e2q_pkg::*;
();

  localparam int RUN_LIMIT = 400000;
  localparam int LONG_HOLD = 300;

  typedef struct {
    q30_t w;
    q30_t x;
    q30_t y;
    q30_t z;
  } quat_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  e2q_in_if  in_if();
  e2q_out_if out_if();

  euler_to_quaternion i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_if),
    .out_chan   (out_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Predictor state: the angle unit and the arctangent table.
  logic   deg_mode;
  longint atan_tab[CORDIC_STAGES];
  quat_t  quat_expected[$];
  int     fail_count;
  int     cycle_count;
  bit     idle_en;
  bit     hold_req;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // Arctangent of 2^-i as a half-angle phase, summed as a power series.
  function automatic void build_atan_tab();
    longint       acc;
    logic [63:0]  term;
    logic [127:0] prod;
    atan_tab[0] = longint'(64'd1 << (ANGLE_BITS - 3));
    for (int i = 1; i < CORDIC_STAGES; i++) begin
      acc = 0;
      for (int k = 0; 62 - i * (2 * k + 1) >= 0; k++) begin
        term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
        if (k % 2 == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      prod = 128'(acc) * 128'(C_RAD);
      prod = prod + (128'd1 << (126 - ANGLE_BITS));
      atan_tab[i] = longint'(prod >> (127 - ANGLE_BITS));
    end
  endfunction

  // Angle word to half-angle phase, one turn = 2^32.
  function automatic logic [31:0] angle_to_phase(input angle_t a, input logic deg);
    logic [32:0]  mag;
    logic [127:0] prod;
    logic [31:0]  ph;
    mag  = a[31] ? (33'h100000000 - {1'b0, a}) : {1'b0, a};
    prod = 128'(mag) * 128'(deg ? C_DEG : C_RAD);
    prod = prod + (128'd1 << (PHASE_SHIFT - 1));
    ph   = prod[PHASE_SHIFT +: 32];
    if (a[31]) ph = -ph;
    return ph;
  endfunction

  function automatic longint clamp_one(input longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  function automatic longint round_q30(input longint v);
    return (v + (64'sd1 << 29)) >>> 30;
  endfunction

  // CORDIC on the residual of the nearest quarter turn, then rotated back.
  function automatic void phase_sincos(input logic [31:0] ph, output longint c,
                                       output longint s);
    logic [31:0] quad;
    logic [31:0] res;
    longint      x, y, z, dx, dy, cr, sr;
    quad = (ph + 32'h20000000) >> 30;
    res  = ph - (quad << 30);
    z = longint'($signed(res));
    x = K_Q40;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_tab[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_tab[i];
      end
    end
    cr = clamp_one((x + 512) >>> 10);
    sr = clamp_one((y + 512) >>> 10);
    case (quad[1:0])
      2'd0: begin c = cr;  s = sr;  end
      2'd1: begin c = -sr; s = cr;  end
      2'd2: begin c = -cr; s = -sr; end
      default: begin c = sr; s = -cr; end
    endcase
  endfunction

  function automatic quat_t predict_quat(input angle_t yaw, input angle_t pitch,
                                         input angle_t roll);
    longint cy, sy, cp, sp, cr, sr, t, u, v, g;
    quat_t  q;
    phase_sincos(angle_to_phase(yaw, deg_mode), cy, sy);
    phase_sincos(angle_to_phase(pitch, deg_mode), cp, sp);
    phase_sincos(angle_to_phase(roll, deg_mode), cr, sr);
    t = round_q30(cy * cp);
    u = round_q30(sy * sp);
    v = round_q30(cy * sp);
    g = round_q30(sy * cp);
    q.w = q30_t'(clamp_one(round_q30(t * cr + u * sr)));
    q.x = q30_t'(clamp_one(round_q30(t * sr - u * cr)));
    q.y = q30_t'(clamp_one(round_q30(v * cr + g * sr)));
    q.z = q30_t'(clamp_one(round_q30(g * cr - v * sr)));
    return q;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (!idle_en || r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Send one angle word and record its quaternion once it is accepted.
  task automatic send_angles(input angle_t yaw, input angle_t pitch, input angle_t roll);
    bit ok;
    int gap;
    in_if.valid       <= 1'b1;
    in_if.yaw_angle   <= yaw;
    in_if.pitch_angle <= pitch;
    in_if.roll_angle  <= roll;
    do begin
      @(negedge clk);
      ok = in_if.ready;
      @(posedge clk);
    end while (!ok);
    quat_expected.push_back(predict_quat(yaw, pitch, roll));
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering words, wait for every result, then let the pipeline empty.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (quat_expected.size() > 0) @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    deg_mode = m;
  endtask

  function automatic angle_t rand_angle();
    int r;
    r = $urandom_range(9);
    if (r < 4) return angle_t'($urandom);
    if (r < 7) return angle_t'($signed($urandom_range(32'h0fffffff)) -
                               32'sh08000000);
    if (r < 8) return angle_t'($urandom_range(3) == 0 ? 32'h80000000 : 32'h7fffffff);
    return angle_t'($signed($urandom_range(16'hffff)) - 32'sh8000);
  endfunction

  // Extremes, zero, and quarter and full turns in both units.
  task automatic test_directed();
    angle_t pi_rad, right_deg;
    pi_rad    = 32'sd421657428;
    right_deg = 32'sd90 <<< 21;
    idle_en = 1'b0;
    write_mode(1'b0);
    send_angles(0, 0, 0);
    send_angles(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_angles(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_angles(-1, 1, -1);
    send_angles(pi_rad, 0, 0);
    send_angles(0, pi_rad >>> 1, 0);
    send_angles(0, 0, -pi_rad);
    send_angles(pi_rad <<< 1, -(pi_rad <<< 1), pi_rad >>> 2);
    send_angles(32'sh7fffffff, 32'sh80000000, 0);
    write_mode(1'b1);
    send_angles(0, 0, 0);
    send_angles(right_deg, right_deg, right_deg);
    send_angles(right_deg <<< 1, -(right_deg <<< 1), 32'sd45 <<< 21);
    send_angles(32'sd360 <<< 21, 32'sd720 <<< 21, -(32'sd540 <<< 21));
    send_angles(32'sh7fffffff, 32'sh80000000, -1);
    send_angles(32'sh80000000, 32'sh7fffffff, 1);
    send_angles(32'sd30 <<< 21, 32'sd60 <<< 21, -(32'sd90 <<< 21));
    idle_en = 1'b1;
  endtask

  task automatic test_random(input int count, input logic m);
    write_mode(m);
    for (int n = 0; n < count; n++) begin
      idle_en = (n % 200) >= 50;
      send_angles(rand_angle(), rand_angle(), rand_angle());
    end
    idle_en = 1'b1;
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall the input.
  task automatic test_backpressure();
    idle_en  = 1'b0;
    hold_req = 1'b1;
    for (int n = 0; n < 80; n++) send_angles(rand_angle(), rand_angle(), rand_angle());
    idle_en = 1'b1;
    drain();
    for (int n = 0; n < 20; n++) send_angles(rand_angle(), rand_angle(), rand_angle());
  endtask

  // Receiver ready, with random stalls and one long hold-off on request.
  initial begin
    int hold_left;
    int stall_left;
    hold_left  = 0;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (idle_en) stall_left = pick_gap();
        out_if.ready <= (stall_left == 0);
      end
    end
  end

  function automatic void check_field(input string name, input q30_t exp_v, input q30_t act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Compare each accepted result word with the oldest prediction.
  initial begin
    quat_t q;
    forever begin
      @(negedge clk);
      if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (quat_expected.size() == 0) begin
          $error("result word with no prediction pending");
          fail_count++;
        end else begin
          q = quat_expected.pop_front();
          check_field("quat_w", q.w, out_if.quat_w);
          check_field("quat_x", q.x, out_if.quat_x);
          check_field("quat_y", q.y, out_if.quat_y);
          check_field("quat_z", q.z, out_if.quat_z);
        end
      end
    end
  end

  initial begin
    fail_count  = 0;
    idle_en     = 1'b1;
    hold_req    = 1'b0;
    deg_mode    = 1'b0;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_if.valid       = 1'b0;
    in_if.yaw_angle   = '0;
    in_if.pitch_angle = '0;
    in_if.roll_angle  = '0;
    build_atan_tab();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(500, 1'b0);
    test_backpressure();
    test_random(400, 1'b1);
    test_random(400, 1'b0);
    drain();
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/e2q_pkg.sv
rtl/e2q_in_if.sv
rtl/e2q_out_if.sv
rtl/e2q_phase.sv
rtl/e2q_cordic.sv
rtl/e2q_combine.sv
rtl/euler_to_quaternion.sv
test/tb_top.sv
